>>> hdl/iirl_pkg.sv
// Shared types and constants for the indexed insert/remove move list.
// No dependencies; used by iirl_cell and indexed_insert_remove_list.
`default_nettype none

package iirl_pkg;

   localparam int CAPACITY = 32;
   localparam int IDX_W    = 6;
   localparam int CSR_W    = 6;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int SLOT_W   = $clog2(CAPACITY);
   localparam int CMP_W    = (CNT_W > IDX_W) ? CNT_W : IDX_W;
   localparam int REQ_W    = 40;
   localparam int RSP_W    = 40;

   typedef enum logic [2:0] {
      OP_READ        = 3'd0,
      OP_INSERT      = 3'd1,
      OP_APPEND      = 3'd2,
      OP_REMOVE      = 3'd3,
      OP_REMOVE_LAST = 3'd4,
      OP_CLEAR       = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_BAD_INDEX = 2'd1,
      ST_FULL      = 2'd2
   } status_type;

   typedef struct packed {
      logic [7:0] eaten;
      logic [7:0] piece;
      logic [2:0] to_col;
      logic [2:0] to_row;
      logic [2:0] from_col;
      logic [2:0] from_row;
   } rec_type;

   typedef struct packed {
      logic             shift_up;
      logic             shift_down;
      logic             rd_en;
      logic [CMP_W-1:0] pos;
   } cell_ctl_type;

endpackage

`default_nettype wire

>>> hdl/iirl_cell.sv
// One list slot: holds a record and moves it up or down the chain.
// Depends on iirl_pkg.
`default_nettype none

module iirl_cell (
   input  wire                         clock,
   input  wire  [iirl_pkg::SLOT_W-1:0] slot,
   input  wire  iirl_pkg::cell_ctl_type ctl,
   input  wire  iirl_pkg::rec_type     new_rec,
   input  wire  iirl_pkg::rec_type     left_rec,
   input  wire  iirl_pkg::rec_type     right_rec,
   output iirl_pkg::rec_type           rec,
   output iirl_pkg::rec_type           rd_rec
);

   iirl_pkg::rec_type             rec_ff;
   iirl_pkg::rec_type             rec_in;
   logic [iirl_pkg::CMP_W-1:0]    here;
   logic                          at_pos;
   logic                          above_pos;

   assign here      = iirl_pkg::CMP_W'(slot);
   assign at_pos    = (here == ctl.pos);
   assign above_pos = (here > ctl.pos);

   always_comb begin
      rec_in = rec_ff;
      if (ctl.shift_up) begin
         if (at_pos)
            rec_in = new_rec;
         else if (above_pos)
            rec_in = left_rec;
      end else if (ctl.shift_down) begin
         if (at_pos || above_pos)
            rec_in = right_rec;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

   assign rec    = rec_ff;
   assign rd_rec = (ctl.rd_en && at_pos) ? rec_ff : '0;

endmodule

`default_nettype wire

>>> hdl/indexed_insert_remove_list.sv
// Top level of the bounded move list: decode, count, result register, cell chain.
// Depends on iirl_pkg and iirl_cell.
//
//  channel | dir | handshake            | payload
//  req     | in  | req_tvalid/tready    | req_tdata  (40b): op, index, record
//  rsp     | out | rsp_tvalid/tready    | rsp_tdata  (40b): status, record, count, flags
//  csr     | in  | csr_wr_en            | csr_wr_data (6b): max_size
//
// One transaction per cycle while req_tready is high; each passes through the cell
// chain into the result register, where all cells shift in parallel.
// req_tready drops only while the result register is held by rsp_tready low.
// Synchronous reset clears the count, the result valid and sets max_size to 32.
// Stored records are not cleared by reset or by a clear operation.
`default_nettype none

module indexed_insert_remove_list (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_tvalid,
   output logic                        req_tready,
   // op[2:0], index[8:3], from_row[11:9], from_col[14:12], to_row[17:15],
   // to_col[20:18], piece[28:21], eaten[36:29], zero[39:37]
   input  wire  [iirl_pkg::REQ_W-1:0]  req_tdata,
   output logic                        rsp_tvalid,
   input  wire                         rsp_tready,
   // status[1:0], out_from_row[4:2], out_from_col[7:5], out_to_row[10:8],
   // out_to_col[13:11], out_piece[21:14], out_eaten[29:22], count[35:30],
   // is_full[36], is_empty[37], zero[39:38]
   output logic [iirl_pkg::RSP_W-1:0]  rsp_tdata,
   input  wire                         csr_wr_en,
   input  wire  [iirl_pkg::CSR_W-1:0]  csr_wr_data
);

   localparam int CAP = iirl_pkg::CAPACITY;

   logic [iirl_pkg::CSR_W-1:0]  max_size_ff;
   logic [iirl_pkg::CNT_W-1:0]  count_ff;
   logic [iirl_pkg::CNT_W-1:0]  count_in;
   logic                        rsp_valid_ff;
   logic [iirl_pkg::RSP_W-1:0]  rsp_data_ff;
   logic [iirl_pkg::RSP_W-1:0]  rsp_data_in;

   logic                        accept;
   logic [2:0]                  op;
   logic [iirl_pkg::IDX_W-1:0]  index;
   iirl_pkg::rec_type           new_rec;
   iirl_pkg::rec_type           rd_rec;
   iirl_pkg::cell_ctl_type      ctl;
   iirl_pkg::status_type        status;
   logic [iirl_pkg::CMP_W-1:0]  idx_c;
   logic [iirl_pkg::CMP_W-1:0]  cnt_c;
   logic [iirl_pkg::CMP_W+1:0]  cap_c;
   logic [iirl_pkg::CMP_W+1:0]  msz_c;
   logic                        full_now;
   logic                        full_after;

   iirl_pkg::rec_type           cell_rec [CAP];
   iirl_pkg::rec_type           cell_rd  [CAP];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign op               = req_tdata[2:0];
   assign index            = req_tdata[8:3];
   assign new_rec.from_row = req_tdata[11:9];
   assign new_rec.from_col = req_tdata[14:12];
   assign new_rec.to_row   = req_tdata[17:15];
   assign new_rec.to_col   = req_tdata[20:18];
   assign new_rec.piece    = req_tdata[28:21];
   assign new_rec.eaten    = req_tdata[36:29];

   assign idx_c = iirl_pkg::CMP_W'(index);
   assign cnt_c = iirl_pkg::CMP_W'(count_ff);
   assign msz_c = (iirl_pkg::CMP_W + 2)'(max_size_ff);

   // capacity in use, clamped to 1..CAPACITY
   always_comb begin
      if (msz_c == '0)
         cap_c = (iirl_pkg::CMP_W + 2)'(1);
      else if (msz_c > (iirl_pkg::CMP_W + 2)'(CAP))
         cap_c = (iirl_pkg::CMP_W + 2)'(CAP);
      else
         cap_c = msz_c;
   end

   assign full_now = ((iirl_pkg::CMP_W + 2)'(cnt_c) >= cap_c);

   always_comb begin
      ctl      = '0;
      status   = iirl_pkg::ST_OK;
      count_in = count_ff;
      case (op)
         iirl_pkg::OP_READ: begin
            if (idx_c < cnt_c) begin
               ctl.rd_en = 1'b1;
               ctl.pos   = idx_c;
            end else begin
               status = iirl_pkg::ST_BAD_INDEX;
            end
         end
         iirl_pkg::OP_INSERT: begin
            if (idx_c > cnt_c) begin
               status = iirl_pkg::ST_BAD_INDEX;
            end else if (full_now) begin
               status = iirl_pkg::ST_FULL;
            end else begin
               ctl.shift_up = 1'b1;
               ctl.pos      = idx_c;
               count_in     = count_ff + 1'b1;
            end
         end
         iirl_pkg::OP_APPEND: begin
            if (full_now) begin
               status = iirl_pkg::ST_FULL;
            end else begin
               ctl.shift_up = 1'b1;
               ctl.pos      = cnt_c;
               count_in     = count_ff + 1'b1;
            end
         end
         iirl_pkg::OP_REMOVE: begin
            if (idx_c >= cnt_c) begin
               status = iirl_pkg::ST_BAD_INDEX;
            end else begin
               ctl.shift_down = 1'b1;
               ctl.pos        = idx_c;
               count_in       = count_ff - 1'b1;
            end
         end
         iirl_pkg::OP_REMOVE_LAST: begin
            if (count_ff == '0) begin
               status = iirl_pkg::ST_BAD_INDEX;
            end else begin
               ctl.shift_down = 1'b1;
               ctl.pos        = cnt_c - 1'b1;
               count_in       = count_ff - 1'b1;
            end
         end
         iirl_pkg::OP_CLEAR: begin
            count_in = '0;
         end
         default: begin
            status = iirl_pkg::ST_BAD_INDEX;
         end
      endcase
      if (!accept) begin
         ctl.shift_up   = 1'b0;
         ctl.shift_down = 1'b0;
      end
   end

   for (genvar i = 0; i < CAP; i++) begin : g_cell
      iirl_cell u_cell (
         .clock     (clock),
         .slot      (iirl_pkg::SLOT_W'(i)),
         .ctl       (ctl),
         .new_rec   (new_rec),
         .left_rec  ((i == 0) ? new_rec : cell_rec[(i == 0) ? 0 : i - 1]),
         .right_rec ((i == CAP - 1) ? cell_rec[i] : cell_rec[(i == CAP - 1) ? i : i + 1]),
         .rec       (cell_rec[i]),
         .rd_rec    (cell_rd[i])
      );
   end

   always_comb begin
      rd_rec = '0;
      for (int i = 0; i < CAP; i++)
         rd_rec = rd_rec | cell_rd[i];
   end

   assign full_after = ((iirl_pkg::CMP_W + 2)'(count_in) >= cap_c);

   always_comb begin
      rsp_data_in        = '0;
      rsp_data_in[1:0]   = status;
      rsp_data_in[4:2]   = rd_rec.from_row;
      rsp_data_in[7:5]   = rd_rec.from_col;
      rsp_data_in[10:8]  = rd_rec.to_row;
      rsp_data_in[13:11] = rd_rec.to_col;
      rsp_data_in[21:14] = rd_rec.piece;
      rsp_data_in[29:22] = rd_rec.eaten;
      rsp_data_in[35:30] = iirl_pkg::IDX_W'(count_in);
      rsp_data_in[36]    = full_after;
      rsp_data_in[37]    = (count_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_size_ff  <= iirl_pkg::CSR_W'(CAP);
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en)
            max_size_ff <= csr_wr_data;
         if (accept) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept)
         rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire
